// ===== sv/hts_pkg.sv =====
// Shared widths, constants and control types for the Huffman tree builder.
`default_nettype none

package hts_pkg;

    localparam int SYM_W       = 8;
    localparam int IN_WEIGHT_W = 24;
    localparam int WEIGHT_W    = 29;
    localparam int NODE_W      = SYM_W + WEIGHT_W;

    localparam logic [SYM_W-1:0] INTERNAL_MARK = 8'd36;

    // Control from the sequencer to the minimum-search unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } t_min_ctl;

endpackage

`default_nettype wire

// ===== sv/hts_if.sv =====
// Valid/ready channel interfaces for the input pairs and the emitted tree nodes.
`default_nettype none

interface hts_in_if
    import hts_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SYM_W-1:0]       symbol;
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   final_symbol;

    modport source (output valid, output symbol, output weight, output final_symbol,
                    input ready);
    modport sink   (input valid, input symbol, input weight, input final_symbol,
                    output ready);
endinterface

interface hts_out_if
    import hts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYM_W-1:0]    node_symbol;
    logic [WEIGHT_W-1:0] node_weight;
    logic                is_internal;
    logic                level_end;
    logic                tree_done;

    modport source (output valid, output node_symbol, output node_weight,
                    output is_internal, output level_end, output tree_done,
                    input ready);
    modport sink   (input valid, input node_symbol, input node_weight,
                    input is_internal, input level_end, input tree_done,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/hts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 63,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/hts_min_unit.sv =====
// Running search for the two lowest-weight nodes, lowest index winning ties.
`default_nettype none

module hts_min_unit
    import hts_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_min_ctl            i_ctl,
    input  wire logic [IDX_W-1:0]    i_idx,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    output logic      [IDX_W-1:0]    o_first_idx,
    output logic      [WEIGHT_W-1:0] o_first_weight,
    output logic      [IDX_W-1:0]    o_second_idx,
    output logic      [WEIGHT_W-1:0] o_second_weight
);

    logic                r_have1;
    logic                r_have2;
    logic [IDX_W-1:0]    r_idx1;
    logic [IDX_W-1:0]    r_idx2;
    logic [WEIGHT_W-1:0] r_w1;
    logic [WEIGHT_W-1:0] r_w2;
    logic                beat_first;
    logic                beat_second;

    // Strict compares keep the earlier index on equal weights.
    assign beat_first  = !r_have1 || (i_weight < r_w1);
    assign beat_second = !r_have2 || (i_weight < r_w2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else if (i_ctl.valid) begin
            if (beat_first) begin
                r_have1 <= 1'b1;
                r_have2 <= r_have1;
            end else if (beat_second) begin
                r_have2 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && !i_ctl.clear) begin
            if (beat_first) begin
                r_idx2 <= r_idx1;
                r_w2   <= r_w1;
                r_idx1 <= i_idx;
                r_w1   <= i_weight;
            end else if (beat_second) begin
                r_idx2 <= i_idx;
                r_w2   <= i_weight;
            end
        end
    end

    assign o_first_idx     = r_idx1;
    assign o_first_weight  = r_w1;
    assign o_second_idx    = r_idx2;
    assign o_second_weight = r_w2;

endmodule

`default_nettype wire

// ===== sv/huffman_tree_builder_top.sv =====
// Huffman tree builder: loads leaves, merges them into a tree, emits it in level order.
//
// Input channel i_in carries (symbol, weight, final_symbol) beats. Each beat
// accepted while loading is stored as a leaf; beats beyond MAX_SYMBOLS leaves are
// dropped. A beat with final_symbol set closes the set and starts the build;
// ready stays low from then until the walk has loaded its last node for output.
// Build: each merge scans the node table once through the two-minimum unit,
// one node per cycle from the node RAM read port, then writes the merged node
// and its two child links.
// Walk: nodes leave on o_out in level order, left to right; each node index is
// read from the queue RAM, then its node and links, and its children are queued.
// level_end marks the last node of each level, tree_done the final node.
// A stall on o_out holds the output register and the walk waits on it; the
// last node may still sit in the output register while the next set loads.
// Reset (synchronous, active low) empties the table and returns to loading.
`default_nettype none

module huffman_tree_builder_top
    import hts_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hts_in_if.sink    i_in,
    hts_out_if.source o_out
);

    localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W      = $clog2(2 * MAX_SYMBOLS);
    localparam int LINK_W     = 2 * IDX_W;

    localparam logic [IDX_W-1:0] MAX_LEAVES = IDX_W'(MAX_SYMBOLS);
    localparam logic [IDX_W-1:0] ONE        = IDX_W'(1);

    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_SCAN_INIT = 4'd1;
    localparam logic [3:0] ST_SCAN      = 4'd2;
    localparam logic [3:0] ST_MERGE     = 4'd3;
    localparam logic [3:0] ST_W_INIT    = 4'd4;
    localparam logic [3:0] ST_W_RDQ     = 4'd5;
    localparam logic [3:0] ST_W_RDN     = 4'd6;
    localparam logic [3:0] ST_W_OUT     = 4'd7;
    localparam logic [3:0] ST_W_PUSH    = 4'd8;

    logic [3:0]            r_state,    n_state;
    logic [NODE_DEPTH-1:0] r_flags,    n_flags;
    logic [IDX_W-1:0]      r_count,    n_count;
    logic [IDX_W-1:0]      r_leaves,   n_leaves;
    logic [IDX_W-1:0]      r_live,     n_live;
    logic [IDX_W-1:0]      r_scan,     n_scan;
    logic                  r_pipe_vld, n_pipe_vld;
    logic [IDX_W-1:0]      r_pipe_idx, n_pipe_idx;
    logic [IDX_W-1:0]      r_head,     n_head;
    logic [IDX_W-1:0]      r_tail,     n_tail;
    logic [IDX_W-1:0]      r_lvl,      n_lvl;
    logic [IDX_W-1:0]      r_idx,      n_idx;
    logic                  r_out_vld;

    logic [SYM_W-1:0]      r_out_sym;
    logic [WEIGHT_W-1:0]   r_out_weight;
    logic                  r_out_int;
    logic                  r_out_lvl_end;
    logic                  r_out_done;

    logic                  in_beat;
    logic                  out_free;
    logic                  out_load;
    logic                  out_level_end;
    logic                  out_last;
    logic                  node_internal;

    logic                  node_we;
    logic [IDX_W-1:0]      node_waddr;
    logic [NODE_W-1:0]     node_wdata;
    logic                  node_re;
    logic [IDX_W-1:0]      node_raddr;
    logic [NODE_W-1:0]     node_rdata;

    logic                  link_we;
    logic [LINK_W-1:0]     link_wdata;
    logic                  link_re;
    logic [LINK_W-1:0]     link_rdata;

    logic                  q_we;
    logic [IDX_W-1:0]      q_waddr;
    logic [IDX_W-1:0]      q_wdata;
    logic                  q_re;
    logic [IDX_W-1:0]      q_rdata;

    t_min_ctl              min_ctl;
    logic [IDX_W-1:0]      min_a;
    logic [IDX_W-1:0]      min_b;
    logic [WEIGHT_W-1:0]   min_wa;
    logic [WEIGHT_W-1:0]   min_wb;

    assign i_in.ready    = (r_state == ST_LOAD);
    assign in_beat       = i_in.valid && i_in.ready;
    assign out_free      = !r_out_vld || o_out.ready;
    assign node_internal = (r_idx >= r_leaves);

    always_comb begin
        n_state    = r_state;
        n_flags    = r_flags;
        n_count    = r_count;
        n_leaves   = r_leaves;
        n_live     = r_live;
        n_scan     = r_scan;
        n_pipe_vld = 1'b0;
        n_pipe_idx = r_pipe_idx;
        n_head     = r_head;
        n_tail     = r_tail;
        n_lvl      = r_lvl;
        n_idx      = r_idx;

        node_we    = 1'b0;
        node_waddr = r_count;
        node_wdata = {i_in.symbol, WEIGHT_W'(i_in.weight)};
        node_re    = 1'b0;
        node_raddr = r_scan;
        link_we    = 1'b0;
        link_wdata = {min_a, min_b};
        link_re    = 1'b0;
        q_we       = 1'b0;
        q_waddr    = r_tail;
        q_wdata    = link_rdata[LINK_W-1:IDX_W];
        q_re       = 1'b0;

        min_ctl.clear = 1'b0;
        min_ctl.valid = r_pipe_vld && r_flags[r_pipe_idx];

        out_load      = 1'b0;
        out_level_end = (r_lvl == ONE);
        out_last      = !node_internal && ((r_head + ONE) == r_tail);

        case (r_state)
            ST_LOAD: begin
                if (in_beat) begin
                    if (r_count < MAX_LEAVES) begin
                        node_we          = 1'b1;
                        n_flags[r_count] = 1'b1;
                        n_count          = r_count + ONE;
                    end
                    if (i_in.final_symbol) begin
                        n_leaves = n_count;
                        n_live   = n_count;
                        n_state  = ST_SCAN_INIT;
                    end
                end
            end
            ST_SCAN_INIT: begin
                if (r_live > ONE) begin
                    n_scan        = '0;
                    min_ctl.clear = 1'b1;
                    n_state       = ST_SCAN;
                end else begin
                    n_state = ST_W_INIT;
                end
            end
            ST_SCAN: begin
                if (r_scan != r_count) begin
                    node_re    = 1'b1;
                    n_pipe_vld = 1'b1;
                    n_pipe_idx = r_scan;
                    n_scan     = r_scan + ONE;
                end else if (!r_pipe_vld) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                node_we          = 1'b1;
                node_wdata       = {INTERNAL_MARK, min_wa + min_wb};
                link_we          = 1'b1;
                n_flags[min_a]   = 1'b0;
                n_flags[min_b]   = 1'b0;
                n_flags[r_count] = 1'b1;
                n_count          = r_count + ONE;
                n_live           = r_live - ONE;
                n_state          = ST_SCAN_INIT;
            end
            ST_W_INIT: begin
                // Seed the queue with the root.
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = r_count - ONE;
                n_head  = '0;
                n_tail  = ONE;
                n_lvl   = '0;
                n_state = ST_W_RDQ;
            end
            ST_W_RDQ: begin
                if (r_head == r_tail) begin
                    n_flags = '0;
                    n_count = '0;
                    n_state = ST_LOAD;
                end else begin
                    if (r_lvl == '0) begin
                        n_lvl = r_tail - r_head;
                    end
                    q_re    = 1'b1;
                    n_state = ST_W_RDN;
                end
            end
            ST_W_RDN: begin
                n_idx      = q_rdata;
                node_re    = 1'b1;
                node_raddr = q_rdata;
                link_re    = 1'b1;
                n_state    = ST_W_OUT;
            end
            ST_W_OUT: begin
                // Hold until the output register can take the beat.
                if (out_free) begin
                    out_load = 1'b1;
                    n_head   = r_head + ONE;
                    n_lvl    = r_lvl - ONE;
                    if (node_internal) begin
                        q_we    = 1'b1;
                        n_tail  = r_tail + ONE;
                        n_state = ST_W_PUSH;
                    end else begin
                        n_state = ST_W_RDQ;
                    end
                end
            end
            ST_W_PUSH: begin
                q_we    = 1'b1;
                q_wdata = link_rdata[IDX_W-1:0];
                n_tail  = r_tail + ONE;
                n_state = ST_W_RDQ;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_flags    <= '0;
            r_count    <= '0;
            r_leaves   <= '0;
            r_live     <= '0;
            r_scan     <= '0;
            r_pipe_vld <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_lvl      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_flags    <= n_flags;
            r_count    <= n_count;
            r_leaves   <= n_leaves;
            r_live     <= n_live;
            r_scan     <= n_scan;
            r_pipe_vld <= n_pipe_vld;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_lvl      <= n_lvl;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_idx <= n_pipe_idx;
        r_idx      <= n_idx;
        if (out_load) begin
            r_out_sym     <= node_rdata[NODE_W-1:WEIGHT_W];
            r_out_weight  <= node_rdata[WEIGHT_W-1:0];
            r_out_int     <= node_internal;
            r_out_lvl_end <= out_level_end;
            r_out_done    <= out_last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.node_symbol = r_out_sym;
    assign o_out.node_weight = r_out_weight;
    assign o_out.is_internal = r_out_int;
    assign o_out.level_end   = r_out_lvl_end;
    assign o_out.tree_done   = r_out_done;

    hts_min_unit #(
        .IDX_W (IDX_W)
    ) u_min (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (min_ctl),
        .i_idx           (r_pipe_idx),
        .i_weight        (node_rdata[WEIGHT_W-1:0]),
        .o_first_idx     (min_a),
        .o_first_weight  (min_wa),
        .o_second_idx    (min_b),
        .o_second_weight (min_wb)
    );

    hts_ram #(
        .WIDTH  (NODE_W),
        .DEPTH  (NODE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    hts_ram #(
        .WIDTH  (LINK_W),
        .DEPTH  (NODE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_count),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (q_rdata),
        .o_rdata (link_rdata)
    );

    hts_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (NODE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Huffman tree builder: directed and random leaf sets, level-order node check.
module tb_top;
    import hts_pkg::*;

    localparam int MAX_SYMBOLS = 32;
    localparam int TABLE_DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int TARGET_PAIRS = 500;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [IN_WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef struct packed {
        logic [SYM_W-1:0]       symbol;
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   final_symbol;
    } t_leaf_pair;

    typedef struct packed {
        logic [SYM_W-1:0]    symbol;
        logic [WEIGHT_W-1:0] weight;
        logic                internal;
        logic                level_end;
        logic                tree_done;
    } t_tree_node;

    typedef enum int {
        WT_FULL,
        WT_TIES,
        WT_EXTREMES
    } t_weight_mix;

    logic i_clk;
    logic i_rst_n;

    hts_in_if  pair_in();
    hts_out_if node_out();

    huffman_tree_builder_top #(.MAX_SYMBOLS(MAX_SYMBOLS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_in),
        .o_out   (node_out)
    );

    t_leaf_pair pending_pairs[$];
    t_tree_node expected_nodes[$];
    int         total_pairs;
    int         idle_phase;
    int         error_count;
    int         nodes_seen;
    int         cycle_count;

    // Shadow of the node table
    logic [WEIGHT_W:0]   tbl_weight [TABLE_DEPTH];
    logic [SYM_W-1:0]    tbl_symbol [TABLE_DEPTH];
    int                  tbl_left   [TABLE_DEPTH];
    int                  tbl_right  [TABLE_DEPTH];
    bit                  tbl_open   [TABLE_DEPTH];
    int                  tbl_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Remove the lightest unmerged node; the lowest index wins a tie.
    function automatic int pop_lightest();
        int  best = 0;
        bit  found = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_open[i] && (!found || tbl_weight[i] < tbl_weight[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        tbl_open[best] = 1'b0;
        return best;
    endfunction

    // Store one pair; on the closing pair merge the tree and queue its level-order walk.
    task automatic load_pair_and_build(input logic [SYM_W-1:0] sym,
                                       input logic [IN_WEIGHT_W-1:0] wt, input logic fin);
        int         leaves;
        int         live;
        int         lo_a;
        int         lo_b;
        int         level_size;
        int         idx;
        int         emitted;
        int         walk[$];
        t_tree_node nd;
        if (tbl_count < MAX_SYMBOLS) begin
            tbl_symbol[tbl_count] = sym;
            tbl_weight[tbl_count] = {{(WEIGHT_W + 1 - IN_WEIGHT_W){1'b0}}, wt};
            tbl_open[tbl_count] = 1'b1;
            tbl_count++;
        end
        if (!fin) return;

        leaves = tbl_count;
        live = leaves;
        while (live > 1 && tbl_count < TABLE_DEPTH) begin
            lo_a = pop_lightest();
            lo_b = pop_lightest();
            tbl_weight[tbl_count] = tbl_weight[lo_a] + tbl_weight[lo_b];
            tbl_symbol[tbl_count] = INTERNAL_MARK;
            tbl_left[tbl_count] = lo_a;
            tbl_right[tbl_count] = lo_b;
            tbl_open[tbl_count] = 1'b1;
            tbl_count++;
            live--;
        end

        emitted = 0;
        walk.push_back(tbl_count - 1);
        while (walk.size() > 0) begin
            level_size = walk.size();
            for (int i = 0; i < level_size; i++) begin
                idx = walk.pop_front();
                nd.symbol = tbl_symbol[idx];
                nd.weight = tbl_weight[idx][WEIGHT_W-1:0];
                nd.internal = (idx >= leaves);
                nd.level_end = (i + 1 == level_size);
                nd.tree_done = (emitted + 1 == tbl_count);
                expected_nodes.push_back(nd);
                emitted++;
                if (nd.internal) begin
                    walk.push_back(tbl_left[idx]);
                    walk.push_back(tbl_right[idx]);
                end
            end
        end

        for (int i = 0; i < TABLE_DEPTH; i++) tbl_open[i] = 1'b0;
        tbl_count = 0;
    endtask

    task automatic add_pair(input logic [SYM_W-1:0] sym, input logic [IN_WEIGHT_W-1:0] wt,
                            input logic fin);
        t_leaf_pair p;
        p.symbol = sym;
        p.weight = wt;
        p.final_symbol = fin;
        pending_pairs.push_back(p);
    endtask

    task automatic add_random_set(input int n, input t_weight_mix mix);
        logic [IN_WEIGHT_W-1:0] wt;
        for (int i = 0; i < n; i++) begin
            case (mix)
                WT_TIES: begin
                    wt = IN_WEIGHT_W'($urandom_range(3));
                end
                WT_EXTREMES: begin
                    case ($urandom_range(2))
                        0:       wt = '0;
                        1:       wt = WEIGHT_MAX;
                        default: wt = IN_WEIGHT_W'($urandom);
                    endcase
                end
                default: begin
                    wt = IN_WEIGHT_W'($urandom);
                end
            endcase
            add_pair(SYM_W'($urandom_range(255)), wt, i == n - 1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("node %0d %s: got %0h want %0h", nodes_seen, name, got, want));
    endtask

    // Sender: hold a beat until it is taken, then maybe idle before the next one.
    always @(posedge i_clk) begin : drive_pairs
        t_leaf_pair nxt;
        int         idle_pct;
        int         pairs_issued;
        if (!i_rst_n) begin
            pair_in.valid <= 1'b0;
            pairs_issued = 0;
        end else if (!pair_in.valid || pair_in.ready) begin
            idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 52 : 0;
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_pairs.pop_front();
                pair_in.valid <= 1'b1;
                pair_in.symbol <= nxt.symbol;
                pair_in.weight <= nxt.weight;
                pair_in.final_symbol <= nxt.final_symbol;
                pairs_issued++;
                idle_phase <= (pairs_issued * 3) / total_pairs;
            end else begin
                pair_in.valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted pair, check every accepted node, stall the node channel.
    always @(posedge i_clk) begin : watch_channels
        t_tree_node want;
        int         stall_pct;
        if (!i_rst_n) begin
            node_out.ready <= 1'b0;
        end else begin
            if (pair_in.valid && pair_in.ready)
                load_pair_and_build(pair_in.symbol, pair_in.weight, pair_in.final_symbol);
            if (node_out.valid && node_out.ready) begin
                nodes_seen++;
                if (expected_nodes.size() == 0) begin
                    report_error($sformatf("node %0d arrived with nothing expected", nodes_seen));
                end else begin
                    want = expected_nodes.pop_front();
                    check_field("node_symbol", 32'(node_out.node_symbol), 32'(want.symbol));
                    check_field("node_weight", 32'(node_out.node_weight), 32'(want.weight));
                    check_field("is_internal", 32'(node_out.is_internal), 32'(want.internal));
                    check_field("level_end", 32'(node_out.level_end), 32'(want.level_end));
                    check_field("tree_done", 32'(node_out.tree_done), 32'(want.tree_done));
                end
            end
            stall_pct = (idle_phase == 0) ? 52 : (idle_phase == 1) ? 34 : 0;
            node_out.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d nodes still expected", expected_nodes.size());
            $display("huffman_tree_builder_top regression: fail");
            $finish;
        end
    end

    initial begin
        int          n;
        int          pick;
        t_weight_mix mix;
        i_rst_n = 1'b0;
        pair_in.valid = 1'b0;
        pair_in.symbol = '0;
        pair_in.weight = '0;
        pair_in.final_symbol = 1'b0;
        node_out.ready = 1'b0;
        idle_phase = 0;
        error_count = 0;
        nodes_seen = 0;
        cycle_count = 0;
        tbl_count = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_open[i] = 1'b0;

        // Single leaf sets at both ends of the ranges
        add_pair(8'hFF, WEIGHT_MAX, 1'b1);
        add_pair(8'h00, '0, 1'b1);
        // Tie between two leaves: the earlier one goes left
        add_pair(8'h41, 24'd5, 1'b0);
        add_pair(8'h42, 24'd5, 1'b1);
        // All zero weights
        add_pair(8'h01, '0, 1'b0);
        add_pair(8'h02, '0, 1'b0);
        add_pair(8'h03, '0, 1'b1);
        // Heaviest leaves, one named like an internal node
        add_pair(INTERNAL_MARK, WEIGHT_MAX, 1'b0);
        add_pair(8'hAA, WEIGHT_MAX, 1'b0);
        add_pair(8'h55, WEIGHT_MAX, 1'b0);
        add_pair(8'h00, 24'd1, 1'b1);
        // Doubling weights give a fully skewed tree
        for (int i = 0; i < 5; i++) add_pair(SYM_W'(8'h61 + i), 24'(1 << i), i == 4);

        while (pending_pairs.size() < TARGET_PAIRS) begin
            pick = $urandom_range(99);
            if (pick < 60)      n = $urandom_range(8, 1);
            else if (pick < 85) n = $urandom_range(20, 9);
            else if (pick < 93) n = $urandom_range(31, 21);
            else if (pick < 97) n = MAX_SYMBOLS;
            else                n = $urandom_range(MAX_SYMBOLS + 4, MAX_SYMBOLS + 1);
            pick = $urandom_range(2);
            mix = (pick == 0) ? WT_FULL : (pick == 1) ? WT_TIES : WT_EXTREMES;
            add_random_set(n, mix);
        end
        total_pairs = pending_pairs.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || pair_in.valid) @(posedge i_clk);
        while (expected_nodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("huffman_tree_builder_top regression: pass");
        end else begin
            $display("huffman_tree_builder_top regression: fail");
        end
        $finish;
    end

endmodule
